FILE: src/ntc_pkg.sv
package ntc_pkg;

    localparam int DUTY_BITS_DEF = 10;
    localparam int ADC_BITS_DEF  = 12;

    localparam int RAW_W      = 12;
    localparam int NR_W       = 36;
    localparam int DR_W       = 32;
    localparam int LOG_W      = 36;
    localparam int DIV_NW     = 64;
    localparam int DIV_DW     = 48;
    localparam int FIFO_DEPTH = 2;

    localparam logic [2:0] CFG_RS   = 3'd0;
    localparam logic [2:0] CFG_R0   = 3'd1;
    localparam logic [2:0] CFG_BETA = 3'd2;
    localparam logic [2:0] CFG_T0   = 3'd3;
    localparam logic [2:0] CFG_LO   = 3'd4;
    localparam logic [2:0] CFG_HI   = 3'd5;

    localparam logic signed [15:0] TEMP_FLOOR = -16'sd5500;
    localparam logic signed [15:0] TEMP_CEIL  = 16'sd25000;
    localparam logic [29:0]        LN2_Q30   = 30'd744261118;
    localparam logic [23:0]        RES_MAX   = 24'hFFFFFF;
    localparam logic [16:0]        KELVIN_CK = 17'd27315;
    localparam logic [63:0]        TC_HI     = 64'd52315;
    localparam logic [63:0]        TC_LO     = 64'd21815;

    typedef struct packed {
        logic [19:0]        rs;
        logic [19:0]        r0;
        logic [13:0]        beta;
        logic signed [14:0] t0;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
    } t_cfg;

    typedef struct packed {
        logic              ok;
        logic              fault;
        logic              raw0;
        logic [RAW_W-1:0]  raw;
        logic [NR_W-1:0]   nr;
        logic [DR_W-1:0]   dr;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic [23:0]        res;
        logic signed [15:0] temp;
        logic               sat;
        logic [13:0]        bright;
        logic [9:0]         duty;
        logic               fault;
        logic               valid;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDIV,
        S_NORM,
        S_SQ,
        S_UPD,
        S_LN,
        S_LN2,
        S_MUL1,
        S_MUL2,
        S_TST,
        S_TDIV,
        S_MAP,
        S_BSTART,
        S_BDIV,
        S_DDIV,
        S_OUT
    } t_state;

endpackage

FILE: src/ntc_front.sv
module ntc_front
    import ntc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [19:0]      i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [RAW_W-1:0] i_raw,
    input  logic             i_ok,
    input  logic             i_full,
    output logic             o_push,
    output t_item            o_item,
    output t_cfg             o_cfg
);

    localparam logic [15:0] FULL = 16'((64'd1 << ADC_BITS) - 64'd1);

    t_cfg        r_cfg;
    logic [15:0] raw_ext;
    logic [15:0] raw_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{rs: 20'd10000, r0: 20'd10000, beta: 14'd3950,
                       t0: 15'sd2500, lo: 16'sd2000, hi: 16'sd4000};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RS:   r_cfg.rs   <= i_cfg_data;
                CFG_R0:   r_cfg.r0   <= i_cfg_data;
                CFG_BETA: r_cfg.beta <= i_cfg_data[13:0];
                CFG_T0:   r_cfg.t0   <= i_cfg_data[14:0];
                CFG_LO:   r_cfg.lo   <= i_cfg_data[15:0];
                CFG_HI:   r_cfg.hi   <= i_cfg_data[15:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        raw_ext      = 16'(i_raw);
        raw_c        = (raw_ext > FULL) ? FULL : raw_ext;
        o_item.ok    = i_ok;
        o_item.raw0  = (raw_c == 16'd0);
        o_item.fault = (raw_c == 16'd0) || (raw_c == FULL);
        o_item.raw   = raw_c[RAW_W-1:0];
        o_item.nr    = NR_W'(r_cfg.rs) * NR_W'(FULL - raw_c);
        o_item.dr    = DR_W'(raw_c[RAW_W-1:0]) * DR_W'(r_cfg.r0);
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_full;
    assign o_push      = i_valid && !i_full;
    assign o_cfg       = r_cfg;

endmodule

FILE: src/ntc_fifo.sv
module ntc_fifo
    import ntc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_avail
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_item          r_mem [FIFO_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(FIFO_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(FIFO_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_avail = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(FIFO_DEPTH));

endmodule

FILE: src/ntc_div.sv
module ntc_div
    import ntc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(DIV_NW);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DIV_NW-1:0] r_q, n_q;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_DW-1:0] r_den, n_den;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    always_comb begin
        trial  = {r_rem, r_q[DIV_NW-1]};
        ge     = (trial >= {1'b0, r_den});
        diff   = trial - {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (!r_busy && i_req.start) begin
            n_q    = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            n_q   = {r_q[DIV_NW-2:0], ge};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(DIV_NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

FILE: src/ntc_back.sv
module ntc_back
    import ntc_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_avail,
    input  t_item    i_item,
    output logic     o_pop,
    output t_div_req o_div_req,
    input  t_div_rsp i_div_rsp,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_result
);

    localparam logic [15:0] DMAX = 16'((64'd1 << DUTY_BITS) - 64'd1);

    t_state             r_state, n_state;
    logic               r_ovalid, n_ovalid;
    t_result            r_out, n_out;
    t_result            r_acc, n_acc;
    t_item              r_item, n_item;
    logic [LOG_W-1:0]   r_x, n_x;
    logic [5:0]         r_e, n_e;
    logic [30:0]        r_m, n_m;
    logic [29:0]        r_lr, n_lr;
    logic [29:0]        r_lnr, n_lnr;
    logic [29:0]        r_ldr, n_ldr;
    logic [4:0]         r_idx, n_idx;
    logic               r_which, n_which;
    logic               r_neg, n_neg;
    logic [61:0]        r_prod, n_prod;
    logic signed [31:0] r_lq, n_lq;
    logic signed [49:0] r_p1, n_p1;
    logic [20:0]        r_b100, n_b100;
    logic [37:0]        r_p2, n_p2;
    logic signed [49:0] r_den, n_den;
    logic [15:0]        r_off, n_off;
    logic [15:0]        r_span, n_span;

    logic signed [17:0] t0c;
    logic [13:0]        beta_eff;
    logic [31:0]        sq;
    logic [29:0]        lr_upd;
    logic signed [30:0] l2;
    logic [29:0]        mag;
    logic [31:0]        q;
    logic [16:0]        tdiff;

    always_comb begin
        n_state   = r_state;
        n_ovalid  = r_ovalid && !i_ready;
        n_out     = r_out;
        n_acc     = r_acc;
        n_item    = r_item;
        n_x       = r_x;
        n_e       = r_e;
        n_m       = r_m;
        n_lr      = r_lr;
        n_lnr     = r_lnr;
        n_ldr     = r_ldr;
        n_idx     = r_idx;
        n_which   = r_which;
        n_neg     = r_neg;
        n_prod    = r_prod;
        n_lq      = r_lq;
        n_p1      = r_p1;
        n_b100    = r_b100;
        n_p2      = r_p2;
        n_den     = r_den;
        n_off     = r_off;
        n_span    = r_span;
        o_pop     = 1'b0;
        o_div_req = '0;
        t0c       = 18'({{3{i_cfg.t0[14]}}, i_cfg.t0}) + 18'sd27315;
        beta_eff  = (i_cfg.beta == 14'd0) ? 14'd1 : i_cfg.beta;
        sq        = r_prod[61:30];
        lr_upd    = sq[31] ? (r_lr | (30'd1 << r_idx)) : r_lr;
        l2        = $signed({1'b0, r_lnr}) - $signed({1'b0, r_ldr});
        mag       = l2[30] ? 30'(-l2) : 30'(l2);
        q         = r_prod[61:30] + 32'(r_prod[29]);
        tdiff     = i_div_rsp.quo[16:0] - KELVIN_CK;

        case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    n_acc  = '0;
                    if (!i_item.ok) begin
                        n_state = S_OUT;
                    end else if (i_item.fault) begin
                        n_acc.res   = i_item.raw0 ? RES_MAX : 24'd0;
                        n_acc.fault = 1'b1;
                        n_acc.valid = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        n_acc.valid     = 1'b1;
                        o_div_req.start = 1'b1;
                        o_div_req.num   = DIV_NW'(i_item.nr);
                        o_div_req.den   = DIV_DW'(i_item.raw);
                        n_state         = S_RDIV;
                    end
                end
            end
            S_RDIV: begin
                if (i_div_rsp.done) begin
                    n_acc.res = (i_div_rsp.quo > DIV_NW'(RES_MAX)) ? RES_MAX
                                                                 : i_div_rsp.quo[23:0];
                    if (r_item.nr == '0) begin
                        n_acc.temp = TEMP_CEIL;
                        n_acc.sat  = 1'b1;
                        n_state    = S_MAP;
                    end else if (r_item.dr == '0) begin
                        n_acc.temp = TEMP_FLOOR;
                        n_acc.sat  = 1'b1;
                        n_state    = S_MAP;
                    end else begin
                        n_x     = LOG_W'(r_item.nr);
                        n_e     = 6'(LOG_W - 1);
                        n_which = 1'b0;
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (r_x[LOG_W-1]) begin
                    n_m     = r_x[LOG_W-1 -: 31];
                    n_lr    = 30'(r_e) << 24;
                    n_idx   = 5'd23;
                    n_state = S_SQ;
                end else begin
                    n_x = r_x << 1;
                    n_e = r_e - 6'd1;
                end
            end
            S_SQ: begin
                n_prod  = 62'(r_m) * 62'(r_m);
                n_state = S_UPD;
            end
            S_UPD: begin
                n_m  = sq[31] ? sq[31:1] : sq[30:0];
                n_lr = lr_upd;
                if (r_idx == 5'd0) begin
                    if (!r_which) begin
                        n_lnr   = lr_upd;
                        n_which = 1'b1;
                        n_x     = LOG_W'(r_item.dr);
                        n_e     = 6'(LOG_W - 1);
                        n_state = S_NORM;
                    end else begin
                        n_ldr   = lr_upd;
                        n_state = S_LN;
                    end
                end else begin
                    n_idx   = r_idx - 5'd1;
                    n_state = S_SQ;
                end
            end
            S_LN: begin
                n_neg   = l2[30];
                n_prod  = 62'(mag) * 62'(LN2_Q30);
                n_state = S_LN2;
            end
            S_LN2: begin
                n_lq    = r_neg ? -$signed(q) : $signed(q);
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_p1    = 50'(r_lq) * 50'(t0c);
                n_b100  = 21'(beta_eff) * 21'd100;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_p2    = 38'(r_b100) * 38'(t0c[16:0]);
                n_den   = r_p1 + $signed(50'({r_b100, 24'd0}));
                n_state = S_TST;
            end
            S_TST: begin
                if (r_den <= 50'sd0) begin
                    n_acc.temp = TEMP_CEIL;
                    n_acc.sat  = 1'b1;
                    n_state    = S_MAP;
                end else begin
                    o_div_req.start = 1'b1;
                    o_div_req.num   = DIV_NW'({r_p2, 24'd0}) + DIV_NW'(r_den[49:1]);
                    o_div_req.den   = r_den[DIV_DW-1:0];
                    n_state         = S_TDIV;
                end
            end
            S_TDIV: begin
                if (i_div_rsp.done) begin
                    if (i_div_rsp.quo > TC_HI) begin
                        n_acc.temp = TEMP_CEIL;
                        n_acc.sat  = 1'b1;
                    end else if (i_div_rsp.quo < TC_LO) begin
                        n_acc.temp = TEMP_FLOOR;
                        n_acc.sat  = 1'b1;
                    end else begin
                        n_acc.temp = tdiff[15:0];
                    end
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                if (r_acc.temp <= i_cfg.lo) begin
                    n_acc.bright = 14'd0;
                    n_acc.duty   = 10'd0;
                    n_state      = S_OUT;
                end else if (r_acc.temp >= i_cfg.hi) begin
                    n_acc.bright = 14'd10000;
                    n_acc.duty   = DMAX[9:0];
                    n_state      = S_OUT;
                end else begin
                    n_off   = 16'(17'(r_acc.temp) - 17'(i_cfg.lo));
                    n_span  = 16'(17'(i_cfg.hi) - 17'(i_cfg.lo));
                    n_state = S_BSTART;
                end
            end
            S_BSTART: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = DIV_NW'(30'(r_off) * 30'd10000);
                o_div_req.den   = DIV_DW'(r_span);
                n_state         = S_BDIV;
            end
            S_BDIV: begin
                if (i_div_rsp.done) begin
                    n_acc.bright    = i_div_rsp.quo[13:0];
                    o_div_req.start = 1'b1;
                    o_div_req.num   = DIV_NW'(32'(r_off) * 32'(DMAX));
                    o_div_req.den   = DIV_DW'(r_span);
                    n_state         = S_DDIV;
                end
            end
            S_DDIV: begin
                if (i_div_rsp.done) begin
                    n_acc.duty = i_div_rsp.quo[9:0];
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_out    = r_acc;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_acc   <= n_acc;
        r_item  <= n_item;
        r_x     <= n_x;
        r_e     <= n_e;
        r_m     <= n_m;
        r_lr    <= n_lr;
        r_lnr   <= n_lnr;
        r_ldr   <= n_ldr;
        r_idx   <= n_idx;
        r_which <= n_which;
        r_neg   <= n_neg;
        r_prod  <= n_prod;
        r_lq    <= n_lq;
        r_p1    <= n_p1;
        r_b100  <= n_b100;
        r_p2    <= n_p2;
        r_den   <= n_den;
        r_off   <= n_off;
        r_span  <= n_span;
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

endmodule

FILE: src/ntc_beta_temperature_to_pwm_duty_core.sv
// Converts NTC divider samples to thermistor resistance, temperature by the beta equation
// and a brightness and PWM duty. A front stage takes samples into a two-entry queue whenever
// there is room, so input is accepted while a result waits at the output register. The back
// end handles one sample at a time: a failed read or a sensor fault goes straight from
// dispatch to the output step, while a normal sample passes through dispatch, the
// resistance divide, normalizing, log squaring, the logarithm scaling and products, the
// temperature divide (saturated cases skip ahead to mapping), mapping, and, when the
// temperature lies between the thresholds, a start step and the brightness and duty
// divides, then the output step, which waits while the output register is still full. The
// shared one-bit-per-cycle divider and the squaring loop set the rate.
module ntc_beta_temperature_to_pwm_duty_core
    import ntc_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF,
    parameter int ADC_BITS  = ADC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // raw_sample[11:0], zero fill
    input  logic [0:0]  s_axis_tuser,   // read_ok
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // resistance_ohms, temperature_centi,
                                        // brightness_centi, duty_value
    output logic [2:0]  m_axis_tuser,   // temp_saturated, sensor_fault, result_valid
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    t_cfg     cfg;
    t_item    push_item;
    t_item    head_item;
    logic     push;
    logic     full;
    logic     pop;
    logic     avail;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_result  result;

    ntc_front #(.ADC_BITS(ADC_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_raw       (s_axis_tdata[RAW_W-1:0]),
        .i_ok        (s_axis_tuser[0]),
        .i_full      (full),
        .o_push      (push),
        .o_item      (push_item),
        .o_cfg       (cfg)
    );

    ntc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_avail (avail)
    );

    ntc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ntc_back #(.DUTY_BITS(DUTY_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_avail   (avail),
        .i_item    (head_item),
        .o_pop     (pop),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (result)
    );

    assign m_axis_tdata = {result.duty, result.bright, result.temp, result.res};
    assign m_axis_tuser = {result.valid, result.fault, result.sat};

endmodule
